@@ hdl/sha256_byte_stream_hasher_macros.svh @@
// Assertion macros for the byte-stream hasher checker.
// Used by the checker file only; no dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Assert that a condition implies a consequence on the same edge.
`define SHA_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence on the next edge.
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/sha_pkg.sv @@
// Package for the byte-stream hasher: constants, types and round functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned LEN_POS      = 56;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Byte source selected by the controller for a buffer write.
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       wr_en;       // write one byte into the buffer
    logic [1:0] wr_src;      // which byte to write
    logic       count_bits;  // add eight to the bit count
    logic       load_w;      // load the schedule window from the buffer
    logic       round;       // run one round
    logic       fold;        // add working words into the chain
    logic       reinit;      // reload initial chain, clear bit count
    logic       shift_out;   // rotate chain for readout
  } sha_cmd_t;

  typedef struct packed {
    logic [6:0] fill;        // bytes in the buffer
    logic [5:0] rnd;         // current round
  } sha_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction
endpackage

@@ hdl/sha_if.sv @@
// Valid/ready channel interface for the byte-stream hasher.
// Depends on nothing; payload width is a parameter.
`timescale 1ns / 1ps
interface sha_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sha_dp.sv @@
// Datapath: block buffer memory, schedule window, round unit, chain words.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  wr_addr,
  input  logic [5:0]  rd_word,
  input  logic [2:0]  len_idx,
  input  logic [5:0]  rnd,
  output logic [31:0] digest_word
);
  // Buffer held as sixteen big-endian words; bytes land in their lane.
  logic [31:0] mem [BLOCK_BYTES / 4];
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] s_r [8];
  logic [63:0] bits_r;
  logic [7:0]  wr_byte;
  logic [31:0] w_new, wt, t1, t2;

  always_comb begin
    unique case (cmd.wr_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bits_r[{len_idx, 3'b000} +: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  assign w_new = w_r[0] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3))
               + w_r[9] + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  assign wt = w_r[0];
  assign t1 = s_r[7] + (rotr(s_r[4], 6) ^ rotr(s_r[4], 11) ^ rotr(s_r[4], 25))
            + ((s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6])) + ROUND_K[rnd] + wt;
  assign t2 = (rotr(s_r[0], 2) ^ rotr(s_r[0], 13) ^ rotr(s_r[0], 22))
            + ((s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_w) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= mem[rd_word[3:0]];
      if (rd_word == 6'd0) begin
        for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      s_r[7] <= s_r[6]; s_r[6] <= s_r[5]; s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2]; s_r[2] <= s_r[1]; s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      bits_r <= 64'd0;
    end else begin
      if (cmd.count_bits) bits_r <= bits_r + 64'd8;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + s_r[i];
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
    end
  end

  assign digest_word = h_r[0];
endmodule

@@ hdl/sha_ctrl.sv @@
// Controller: sequences byte writes, padding, compressions and readout.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       byte_present,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] word_pos,
  output sha_cmd_t   cmd,
  output logic [5:0] wr_addr,
  output logic [5:0] rd_word,
  output logic [2:0] len_idx,
  output sha_stat_t  stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [6:0] fill_r, fill_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;   // pad byte 0x80 still to be written
  logic       last_r, last_nxt; // this compression is the final one
  // A non-final compression during padding leaves zero and length bytes to go.
  logic       pad_r, pad_nxt;
  logic       acc;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign acc       = in_valid && in_ready;
  assign word_pos  = cnt_r[2:0];
  assign rd_word   = cnt_r;
  assign len_idx   = 3'(6'd63 - fill_r[5:0]);
  assign wr_addr   = fill_r[5:0];
  assign stat      = '{fill: fill_r, rnd: cnt_r};

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; cnt_nxt = cnt_r;
    fin_nxt = fin_r; last_nxt = last_r;
    cmd = '0;
    cmd.wr_src = SRC_DATA;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (byte_present) begin
            cmd.wr_en = 1'b1; cmd.count_bits = 1'b1;
            fill_nxt = fill_r + 7'd1;
          end
          fin_nxt = end_of_message;
          if (byte_present && fill_r == 7'd63) begin
            st_nxt = S_LOAD; cnt_nxt = '0; last_nxt = 1'b0;
          end else if (end_of_message) begin
            st_nxt = S_PAD;
            if (byte_present) fill_nxt = fill_r + 7'd1;
          end
        end
      end
      S_PAD: begin
        // write 0x80 first, then zeros, then the length bytes
        cmd.wr_en = 1'b1;
        if (fin_r) begin
          cmd.wr_src = SRC_PAD; fin_nxt = 1'b0;
        end else if (last_r) begin
          cmd.wr_src = SRC_LEN;
        end else begin
          cmd.wr_src = SRC_ZERO;
        end
        fill_nxt = fill_r + 7'd1;
        if (fill_r == 7'd63) begin
          st_nxt = S_LOAD; cnt_nxt = '0;
        end else if (fill_nxt == 7'(LEN_POS) && !(fin_r && fill_r > 7'(LEN_POS - 1))) begin
          last_nxt = 1'b1;
        end
        if (fin_r && fill_r >= 7'(LEN_POS)) last_nxt = 1'b0;
        else if (fin_r && fill_r == 7'(LEN_POS - 1)) last_nxt = 1'b1;
      end
      S_LOAD: begin
        cmd.load_w = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          st_nxt = S_RND; cnt_nxt = '0;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(ROUNDS - 1)) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        fill_nxt = '0; cnt_nxt = '0;
        if (last_r) begin
          st_nxt = S_OUT;
        end else if (fin_r) begin
          st_nxt = S_PAD;  // full block came with end of message
        end else if (pad_r) begin
          st_nxt = S_PAD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd7) begin
            cmd.reinit = 1'b1; st_nxt = S_IDLE; cnt_nxt = '0;
            last_nxt = 1'b0; fill_nxt = '0;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pad_nxt = pad_r;
    if (st_r == S_PAD) pad_nxt = 1'b1;
    if (st_r == S_IDLE || st_r == S_OUT) pad_nxt = 1'b0;
    if (st_r == S_FOLD && last_r) pad_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fill_r <= '0; cnt_r <= '0;
      fin_r <= 1'b0; last_r <= 1'b0; pad_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; cnt_r <= cnt_nxt;
      fin_r <= fin_nxt; last_r <= last_nxt; pad_r <= pad_nxt;
    end
  end
endmodule

@@ hdl/sha256_byte_stream_hasher.sv @@
// Channel   | dir | payload
// in        | in  | data_byte[7:0], byte_present, end_of_message
// out       | out | digest_word[31:0], word_position[2:0], last_word
//
// A byte item is taken while the input is ready; a full buffer costs a
// 16-word window load, 64 rounds and one fold in the single round unit.
// End of message adds the padding writes (one byte a cycle) and one or two
// compressions, then eight readout transactions.
// Reset is synchronous, active low; it reloads the chain and clears the count.
// The input stalls while a compression, padding or readout is under way.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sha_if.sink   in_ch,
  sha_if.source out_ch
);
  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [5:0]  wr_addr, rd_word;
  logic [2:0]  len_idx, word_pos;
  logic [31:0] digest_word;

  // Hold the sequencing in the controller.
  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .byte_present(in_ch.data[8]), .end_of_message(in_ch.data[9]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_pos, .cmd, .wr_addr, .rd_word, .len_idx, .stat
  );

  // Advance the hash arithmetic in the datapath.
  sha_dp u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_ch.data[7:0]),
    .wr_addr, .rd_word, .len_idx, .rnd(stat.rnd), .digest_word
  );

  assign out_ch.data = {(word_pos == 3'd7), word_pos, digest_word};
endmodule

@@ hdl/sha_chk.sv @@
// Port checker for the hasher, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_macros.svh"
module sha_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [35:0] out_data
);
  `SHA_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready, "input taken during readout")
  `SHA_ASSERT_IMPL(a_last, clk, rst_n, out_valid, out_data[35] == (out_data[34:32] == 3'd7), "last flag wrong")
  `SHA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data), "stalled word moved")
  `SHA_ASSERT_NEXT(a_step, clk, rst_n, out_valid && out_ready && out_data[34:32] != 3'd7, out_valid, "readout broke off")
endmodule

bind sha256_byte_stream_hasher sha_chk u_chk (
  .clk, .rst_n, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);
